FILE: rtl/assert_macros.svh
// Assertion macros shared by the list unit modules.
// Empty bodies when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OLST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OLST_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define OLST_ASSERT(lbl, clk, rst_n, prop, msg)
`define OLST_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/olst_pkg.sv
// Shared types and constants of the ordered list unit.
// No dependencies; used by the interfaces and all modules.
package olst_pkg;

    localparam int DEF_CAPACITY     = 64;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam int ACT_W     = 3;
    localparam int POS_W     = 7;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int STAT_W    = 3;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND  = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_RMFIRST = 3'd2,
        ACT_RMLAST  = 3'd3,
        ACT_RMPOS   = 3'd4,
        ACT_RMKEY   = 3'd5,
        ACT_CLEAR   = 3'd6,
        ACT_READ    = 3'd7
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_EMPTY  = 3'd2,
        STAT_BADPOS = 3'd3,
        STAT_NOKEY  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic find;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/olst_if.sv
// Request and response channel interfaces of the ordered list unit.
// Depends on olst_pkg for field widths.
interface olst_req_if;
    import olst_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] item_key;
    logic [PAY_W-1:0]        item_payload;

    modport source (output valid, action, position, item_key, item_payload, input ready);
    modport sink   (input valid, action, position, item_key, item_payload, output ready);
endinterface

interface olst_rsp_if;
    import olst_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]        out_payload;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    is_empty;
    logic                    is_full;

    modport source (output valid, status, out_key, out_payload, entry_count, is_empty,
                    is_full, input ready);
    modport sink   (input valid, status, out_key, out_payload, entry_count, is_empty,
                    is_full, output ready);
endinterface

FILE: rtl/olst_ctrl.sv
// Sequencer of the ordered list unit: accept, find, execute.
// Depends on olst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module olst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  olst_pkg::stat_t stat,
    output logic           in_ready,
    output olst_pkg::cmd_t cmd
);
    import olst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = req_valid ? S_FIND : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_FIND:
            begin
                cmd.find = 1'b1;
            end
            S_EXEC:
            begin
                in_ready = stat.out_free;
                cmd.exec = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.load = req_valid && in_ready;
    end

    `OLST_ASSERT(a_find_then_exec, clk, rst_n, (state_reg == S_FIND) |=> (state_reg == S_EXEC), "find not followed by exec")
    `OLST_ASSERT(a_load_to_find, clk, rst_n, cmd.load |=> (state_reg == S_FIND), "accepted beat did not start a search")
    `OLST_ASSERT(a_exec_holds, clk, rst_n, (state_reg == S_EXEC && !stat.out_free) |=> (state_reg == S_EXEC), "exec left while output blocked")

endmodule

FILE: rtl/olst_dp.sv
// Datapath of the ordered list unit: entry cells, search, shift and result register.
// Depends on olst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module olst_dp #(
    parameter int CAPACITY     = olst_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = olst_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  olst_pkg::cmd_t                    cmd,
    output olst_pkg::stat_t                   stat,
    input  logic [olst_pkg::ACT_W-1:0]        action,
    input  logic [olst_pkg::POS_W-1:0]        position,
    input  logic signed [olst_pkg::KEY_W-1:0] item_key,
    input  logic [olst_pkg::PAY_W-1:0]        item_payload,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic [olst_pkg::STAT_W-1:0]       status,
    output logic signed [olst_pkg::KEY_W-1:0] out_key,
    output logic [olst_pkg::PAY_W-1:0]        out_payload,
    output logic [olst_pkg::CNT_OUT_W-1:0]    entry_count,
    output logic                              is_empty,
    output logic                              is_full
);
    import olst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    action_t                 act_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [KEY_W-1:0]        keys_reg [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pays_reg [CAPACITY];
    logic [KEY_W-1:0]        dn_key   [CAPACITY];
    logic [KEY_W-1:0]        up_key   [CAPACITY];
    logic [PAYLOAD_BITS-1:0] dn_pay   [CAPACITY];
    logic [PAYLOAD_BITS-1:0] up_pay   [CAPACITY];

    logic [CAPACITY-1:0]     sel_reg;
    logic [CAPACITY-1:0]     sel_next;
    status_t                 st_reg;
    status_t                 st_next;

    logic [CAPACITY-1:0]     in_list;
    logic [CAPACITY-1:0]     at_pos;
    logic [CAPACITY-1:0]     at_cnt;
    logic [CAPACITY-1:0]     at_last;
    logic [CAPACITY-1:0]     match;
    logic [CAPACITY-1:0]     first;
    logic [CAPACITY-1:0]     ge;

    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic                    list_full;
    logic                    list_empty;
    logic                    ins_op;
    logic                    drop_op;
    logic                    clr_op;
    logic                    ret_op;
    logic                    upd_ok;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    logic                    out_valid_reg;
    status_t                 status_reg;
    logic [KEY_W-1:0]        out_key_reg;
    logic [PAY_W-1:0]        out_pay_reg;
    logic [CNT_OUT_W-1:0]    out_cnt_reg;
    logic                    empty_reg;
    logic                    full_reg;

    // beat capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_CLEAR;
        end
        else if (cmd.load)
        begin
            act_reg <= action_t'(action);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg <= position;
            key_reg <= item_key;
            pay_reg <= PAYLOAD_BITS'(item_payload);
        end
    end

    assign pos_ext    = CMP_W'(pos_reg);
    assign cnt_ext    = CMP_W'(count_reg);
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);

    // per-cell compares
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            in_list[i] = (CNT_W'(i) < count_reg);
            at_pos[i]  = (CMP_W'(i) == pos_ext);
            at_cnt[i]  = (CNT_W'(i) == count_reg);
            at_last[i] = (CNT_W'(i + 1) == count_reg);
            match[i]   = in_list[i] && (keys_reg[i] == key_reg);
        end
    end

    assign first = match & (~match + CAPACITY'(1));

    always_comb
    begin
        ins_op  = 1'b0;
        drop_op = 1'b0;
        clr_op  = 1'b0;
        ret_op  = 1'b0;
        unique case (act_reg) inside
            ACT_APPEND, ACT_INSERT:
            begin
                ins_op = 1'b1;
            end
            ACT_RMFIRST, ACT_RMLAST, ACT_RMPOS, ACT_RMKEY:
            begin
                drop_op = 1'b1;
                ret_op  = 1'b1;
            end
            ACT_READ:
            begin
                ret_op = 1'b1;
            end
            ACT_CLEAR:
            begin
                clr_op = 1'b1;
            end
        endcase
    end

    // find: pick target cell and status
    always_comb
    begin
        st_next  = STAT_OK;
        sel_next = '0;
        unique case (act_reg) inside
            ACT_APPEND:
            begin
                st_next  = list_full ? STAT_FULL : STAT_OK;
                sel_next = at_cnt;
            end
            ACT_INSERT:
            begin
                if (list_full)
                begin
                    st_next = STAT_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    st_next = STAT_BADPOS;
                end
                sel_next = at_pos;
            end
            ACT_RMFIRST:
            begin
                st_next  = list_empty ? STAT_EMPTY : STAT_OK;
                sel_next = CAPACITY'(1);
            end
            ACT_RMLAST:
            begin
                st_next  = list_empty ? STAT_EMPTY : STAT_OK;
                sel_next = at_last;
            end
            ACT_RMPOS, ACT_READ:
            begin
                if (list_empty)
                begin
                    st_next = STAT_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    st_next = STAT_BADPOS;
                end
                sel_next = at_pos;
            end
            ACT_RMKEY:
            begin
                if (list_empty)
                begin
                    st_next = STAT_EMPTY;
                end
                else if (first == '0)
                begin
                    st_next = STAT_NOKEY;
                end
                sel_next = first;
            end
            ACT_CLEAR:
            begin
                st_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.find)
        begin
            sel_reg <= sel_next;
            st_reg  <= st_next;
        end
    end

    // execute: on insert or remove, shift cells at and above the target
    assign ge     = ~(sel_reg - CAPACITY'(1));
    assign upd_ok = cmd.exec && (st_reg == STAT_OK);

    always_comb
    begin
        rd_key = '0;
        rd_pay = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (sel_reg[i])
            begin
                rd_key = rd_key | keys_reg[i];
                rd_pay = rd_pay | pays_reg[i];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_lo
            assign dn_key[g] = key_reg;
            assign dn_pay[g] = pay_reg;
        end
        else
        begin : g_lo
            assign dn_key[g] = keys_reg[g-1];
            assign dn_pay[g] = pays_reg[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_hi
            assign up_key[g] = keys_reg[g];
            assign up_pay[g] = pays_reg[g];
        end
        else
        begin : g_hi
            assign up_key[g] = keys_reg[g+1];
            assign up_pay[g] = pays_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (upd_ok && ge[g])
            begin
                if (ins_op)
                begin
                    keys_reg[g] <= sel_reg[g] ? key_reg : dn_key[g];
                    pays_reg[g] <= sel_reg[g] ? pay_reg : dn_pay[g];
                end
                else if (drop_op)
                begin
                    keys_reg[g] <= up_key[g];
                    pays_reg[g] <= up_pay[g];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (upd_ok)
        begin
            if (ins_op)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (drop_op)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            else if (clr_op)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg  <= st_reg;
            out_key_reg <= (upd_ok && ret_op) ? rd_key : '0;
            out_pay_reg <= (upd_ok && ret_op) ? PAY_W'(rd_pay) : '0;
            out_cnt_reg <= CNT_OUT_W'(count_next);
            empty_reg   <= (count_next == '0);
            full_reg    <= (count_next == CNT_W'(CAPACITY));
        end
    end

    assign stat.out_free = !out_valid_reg || rsp_ready;
    assign rsp_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_key       = out_key_reg;
    assign out_payload   = out_pay_reg;
    assign entry_count   = out_cnt_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;

    `OLST_ASSERT(a_sel_onehot, clk, rst_n, cmd.exec |-> $onehot0(sel_reg), "target select not one-hot")
    `OLST_ASSERT(a_ins_count, clk, rst_n, (upd_ok && ins_op) |=> (count_reg == $past(count_reg) + CNT_W'(1)), "insert did not grow count")
    `OLST_ASSERT(a_exec_result, clk, rst_n, cmd.exec |=> rsp_valid, "execute did not post a result")
    `OLST_ASSERT_NEVER(a_no_overfill, clk, rst_n, upd_ok && ins_op && list_full, "insert on a full list")

endmodule

FILE: rtl/ordered_array_list_unit.sv
// Ordered list unit: up to CAPACITY keyed entries held in shifting register cells.
// Request beat: action, position, item_key, item_payload on req (valid/ready).
// Response beat: status, out_key, out_payload, entry_count, is_empty, is_full on rsp.
// Every request beat yields exactly one response beat, in order.
// A request is captured when accepted; the find state then searches the cells and
// picks the target, and the exec state shifts the cells and registers the response.
// No new request is taken while one is searching; each passes the search then shift
// pair on the cell array, and a new request is taken in the same cycle the previous one executes.
// A finished response waits in the output register while a new request is taken;
// if rsp stays stalled, execution of the next request waits for the output register.
// Reset empties the list (count zero) and drops any pending response; the entry
// cells are not cleared and only entries below the count are ever read.
// Depends on olst_pkg, olst_if, olst_ctrl and olst_dp.
module ordered_array_list_unit #(
    parameter int CAPACITY     = olst_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = olst_pkg::DEF_PAYLOAD_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    olst_req_if.sink   req,
    olst_rsp_if.source rsp
);
    import olst_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign req.ready = in_ready;

    olst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    olst_dp #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (req.action),
        .position     (req.position),
        .item_key     (req.item_key),
        .item_payload (req.item_payload),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .status       (rsp.status),
        .out_key      (rsp.out_key),
        .out_payload  (rsp.out_payload),
        .entry_count  (rsp.entry_count),
        .is_empty     (rsp.is_empty),
        .is_full      (rsp.is_full)
    );

endmodule
